>>> design/nhm_pkg.sv
package nhm_pkg;

  // Table size limits and defaults.
  localparam int NODE_SLOTS_DEFAULT = 16;
  localparam int SLOT_W             = 6;
  localparam int MAX_RESULTS        = 16;
  localparam int KCOUNT_W           = 5;

  // Register reset values.
  localparam logic [7:0]  EXPECTED_LENGTH_RESET = 8'd25;
  localparam logic [31:0] LATE_TIMEOUT_RESET    = 32'd10000;
  localparam logic [15:0] TIME_WINDOW_RESET     = 16'd1000;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd0;
  localparam logic [1:0] REG_LATE_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_TIME_WINDOW     = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_WARNING = 2'd1;
  localparam logic [1:0] KIND_ALERT   = 2'd2;

  // Receive status codes.
  localparam logic [2:0] ST_IGNORED    = 3'd0;
  localparam logic [2:0] ST_ACCEPTED   = 3'd1;
  localparam logic [2:0] ST_ACCEPT_BAD = 3'd2;
  localparam logic [2:0] ST_DROPPED    = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // Bit positions of the node marks.
  localparam int MARK_SKIP   = 0;
  localparam int MARK_BADSIG = 1;
  localparam int MARK_SUSP   = 2;

  // The request token that travels along the row of cells.
  typedef struct packed {
    logic                active;
    logic                is_check;
    logic [KCOUNT_W-1:0] kcount;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [7:0]          seq;
    logic [31:0]         offset;
    logic [2:0]          marks;
    logic                emit;
    logic [1:0]          emit_kind;
    logic [15:0]         emit_addr;
    logic                emit_skip;
  } probe_t;

  // Entry write broadcast to all cells.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       address;
    logic [7:0]        seq;
    logic [31:0]       seen;
    logic [31:0]       remote;
    logic [31:0]       offset;
    logic [2:0]        marks;
  } write_t;

endpackage

>>> design/nhm_cell.sv
module nhm_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  nhm_pkg::probe_t probe_in,
  input  logic            occupied,
  input  logic [31:0]     now_ms,
  input  logic [15:0]     source_address,
  input  logic [31:0]     late_timeout_ms,
  input  nhm_pkg::write_t wr,
  output nhm_pkg::probe_t probe_out
);

  logic [15:0] address;
  logic [7:0]  seq;
  logic [31:0] seen;
  logic [31:0] remote;
  logic [31:0] offset;
  logic [2:0]  marks;

  logic            here;
  logic            late;
  logic            bad;
  logic            report;
  nhm_pkg::probe_t probe_next;

  assign here = (wr.slot == nhm_pkg::SLOT_W'(INDEX));

  // Late or badly signed nodes are reported on a check request.
  assign late   = (now_ms - seen) > late_timeout_ms;
  assign bad    = late || marks[nhm_pkg::MARK_BADSIG];
  assign report = probe_in.active && probe_in.is_check && occupied && bad &&
                  (probe_in.kcount < nhm_pkg::KCOUNT_W'(nhm_pkg::MAX_RESULTS));

  // Update the travelling request as it passes this entry.
  always_comb begin
    probe_next      = probe_in;
    probe_next.emit = 1'b0;
    if (probe_in.active && !probe_in.is_check && !probe_in.found && occupied &&
        address == source_address) begin
      probe_next.found  = 1'b1;
      probe_next.slot   = nhm_pkg::SLOT_W'(INDEX);
      probe_next.seq    = seq;
      probe_next.offset = offset;
      probe_next.marks  = marks;
    end
    if (report) begin
      probe_next.emit      = 1'b1;
      probe_next.emit_addr = address;
      probe_next.emit_skip = marks[nhm_pkg::MARK_SKIP];
      probe_next.emit_kind = marks[nhm_pkg::MARK_SUSP] ? nhm_pkg::KIND_ALERT
                                                        : nhm_pkg::KIND_WARNING;
      probe_next.kcount    = probe_in.kcount + 1'b1;
    end
  end

  // Hand the request on to the neighbour.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
      probe_out.emit   <= 1'b0;
    end else begin
      probe_out <= probe_next;
    end
  end

  // Entry storage: written by the controller or marked on a warning.
  always_ff @(posedge clk) begin
    if (wr.we && here) begin
      address <= wr.address;
      seq     <= wr.seq;
      seen    <= wr.seen;
      remote  <= wr.remote;
      offset  <= wr.offset;
      marks   <= wr.marks;
    end else if (report && !marks[nhm_pkg::MARK_SUSP]) begin
      marks[nhm_pkg::MARK_SUSP]   <= 1'b1;
      marks[nhm_pkg::MARK_BADSIG] <= 1'b0;
    end
  end

endmodule

>>> design/neighbour_heartbeat_monitor.sv
// Walk: a request walks the row of NODE_SLOTS cells, one cell per cycle. The receive
// status, or the last warning of a check, is registered after the request has passed the
// row and the decide or finish state, and appears in the same cycle that busy falls.
// One request at a time: a new request is accepted only once the last is through and
// busy is low. The receiver cannot stall the results.
// Reset (rst, synchronous) empties the table and restores register defaults.
module neighbour_heartbeat_monitor #(
  parameter int NODE_SLOTS = nhm_pkg::NODE_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] now_ms,
  input  logic [15:0] source_address,
  input  logic [7:0]  payload_length,
  input  logic [7:0]  seq_byte,
  input  logic [31:0] remote_time,
  input  logic        signature_ok,
  output logic        result_valid,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic [15:0] node_address,
  output logic        sequence_skipped,
  output logic        last_result
);

  localparam int COUNT_W = $clog2(NODE_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [7:0]  expected_length;
  logic [31:0] late_timeout_ms;
  logic [15:0] time_window_ms;

  logic [COUNT_W-1:0] entry_count;

  // Latched request.
  logic        item_check;
  logic [31:0] item_now;
  logic [15:0] item_addr;
  logic [7:0]  item_len;
  logic [7:0]  item_seq;
  logic [31:0] item_rtime;
  logic        item_sig;
  logic [31:0] item_diff;

  nhm_pkg::probe_t probe_chain [NODE_SLOTS+1];
  nhm_pkg::probe_t probe_head;
  logic [NODE_SLOTS-1:0] occupied;
  nhm_pkg::write_t wr;
  nhm_pkg::probe_t final_probe;
  nhm_pkg::probe_t lookup;

  // Pending check result, held until the next one shows whether it is last.
  logic        pend_valid;
  logic [1:0]  pend_kind;
  logic [15:0] pend_addr;
  logic        pend_skip;

  logic        walk_done;
  logic        any_emit;
  logic [1:0]  em_kind;
  logic [15:0] em_addr;
  logic        em_skip;

  assign busy           = (state != S_IDLE);
  assign probe_chain[0] = probe_head;
  assign final_probe    = probe_chain[NODE_SLOTS];
  assign walk_done      = final_probe.active;

  // The row of cells.
  for (genvar i = 0; i < NODE_SLOTS; i++) begin : g_cell
    assign occupied[i] = entry_count > COUNT_W'(i);
    nhm_cell #(.INDEX(i)) u_cell (
      .clk             (clk),
      .rst             (rst),
      .probe_in        (probe_chain[i]),
      .occupied        (occupied[i]),
      .now_ms          (item_now),
      .source_address  (item_addr),
      .late_timeout_ms (late_timeout_ms),
      .wr              (wr),
      .probe_out       (probe_chain[i+1])
    );
  end

  // Pick up a report from whichever cell the request is in.
  always_comb begin
    any_emit = 1'b0;
    em_kind  = nhm_pkg::KIND_WARNING;
    em_addr  = '0;
    em_skip  = 1'b0;
    for (int i = 1; i <= NODE_SLOTS; i++) begin
      if (probe_chain[i].emit) begin
        any_emit = 1'b1;
        em_kind  = probe_chain[i].emit_kind;
        em_addr  = probe_chain[i].emit_addr;
        em_skip  = probe_chain[i].emit_skip;
      end
    end
  end

  // Receive decision from the lookup captured at the end of the row.
  logic [31:0] n_seq_base;
  logic [31:0] n_off;
  logic [2:0]  n_marks;
  logic [7:0]  n_seq;
  logic [31:0] d;
  logic signed [32:0] d_ext;
  logic signed [32:0] win;
  logic        in_window;
  logic signed [32:0] sum;
  logic signed [32:0] avg;
  logic [2:0]  dec_status;
  logic        dec_store;
  logic        dec_skip;
  logic        table_full;
  logic        seq_skip;

  always_comb begin
    n_seq_base = {24'd0, lookup.found ? lookup.seq : item_seq};
    n_off      = lookup.found ? lookup.offset : item_diff;
    n_marks    = lookup.found ? lookup.marks : 3'b000;
    n_seq      = n_seq_base[7:0];
    seq_skip   = (n_seq_base[7:0] + 8'd1) != item_seq;
    d          = item_diff - n_off;
    d_ext      = $signed({d[31], d});
    win        = $signed({17'd0, time_window_ms});
    in_window  = (d_ext < win) && (d_ext > -win);
    sum        = $signed({n_off[31], n_off}) + $signed({item_diff[31], item_diff});
    avg        = (sum + $signed({32'd0, sum[32]})) >>> 1;
    table_full = (entry_count == COUNT_W'(NODE_SLOTS));
    dec_status = nhm_pkg::ST_DROPPED;

    if (item_sig) begin
      n_marks[nhm_pkg::MARK_BADSIG] = 1'b0;
      if (lookup.found) begin
        n_marks[nhm_pkg::MARK_SKIP] = seq_skip;
      end
      n_seq      = item_seq;
      n_off      = item_diff;
      dec_status = nhm_pkg::ST_ACCEPTED;
    end else if (in_window) begin
      n_off      = avg[31:0];
      n_marks[nhm_pkg::MARK_BADSIG] = 1'b1;
      dec_status = nhm_pkg::ST_ACCEPT_BAD;
    end

    if (dec_status != nhm_pkg::ST_DROPPED && !lookup.found && table_full) begin
      dec_status = nhm_pkg::ST_FULL;
    end
    if (item_len != expected_length) begin
      dec_status = nhm_pkg::ST_IGNORED;
    end

    dec_store = (dec_status == nhm_pkg::ST_ACCEPTED) ||
                (dec_status == nhm_pkg::ST_ACCEPT_BAD);
    if (dec_store) begin
      dec_skip = n_marks[nhm_pkg::MARK_SKIP];
    end else if (dec_status == nhm_pkg::ST_IGNORED) begin
      dec_skip = 1'b0;
    end else begin
      dec_skip = lookup.found && lookup.marks[nhm_pkg::MARK_SKIP];
    end

    wr.we      = (state == S_DECIDE) && dec_store;
    wr.slot    = lookup.found ? lookup.slot : nhm_pkg::SLOT_W'(entry_count);
    wr.address = item_addr;
    wr.seq     = n_seq;
    wr.seen    = item_now;
    wr.remote  = item_rtime;
    wr.offset  = n_off;
    wr.marks   = n_marks;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= nhm_pkg::EXPECTED_LENGTH_RESET;
      late_timeout_ms <= nhm_pkg::LATE_TIMEOUT_RESET;
      time_window_ms  <= nhm_pkg::TIME_WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        nhm_pkg::REG_EXPECTED_LENGTH: expected_length <= cfg_data[7:0];
        nhm_pkg::REG_LATE_TIMEOUT:    late_timeout_ms <= cfg_data;
        nhm_pkg::REG_TIME_WINDOW:     time_window_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Latch the request on acceptance.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_check <= action;
      item_now   <= now_ms;
      item_addr  <= source_address;
      item_len   <= payload_length;
      item_seq   <= seq_byte;
      item_rtime <= remote_time;
      item_sig   <= signature_ok;
      item_diff  <= remote_time - now_ms;
    end
  end

  // Sequencer, request injection and result output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      probe_head   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          result_valid <= 1'b0;
          if (start) begin
            probe_head <= '{active: 1'b1, is_check: action, default: '0};
            pend_valid <= 1'b0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          probe_head.active <= 1'b0;
          result_valid      <= any_emit && pend_valid;
          if (any_emit) begin
            if (pend_valid) begin
              kind             <= pend_kind;
              status           <= nhm_pkg::ST_IGNORED;
              node_address     <= pend_addr;
              sequence_skipped <= pend_skip;
              last_result      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_kind  <= em_kind;
            pend_addr  <= em_addr;
            pend_skip  <= em_skip;
          end
          if (walk_done) begin
            lookup <= final_probe;
            state  <= item_check ? S_FINISH : S_DECIDE;
          end
        end
        S_DECIDE: begin
          result_valid     <= 1'b1;
          kind             <= nhm_pkg::KIND_STATUS;
          status           <= dec_status;
          node_address     <= item_addr;
          sequence_skipped <= dec_skip;
          last_result      <= 1'b1;
          if (dec_store && !lookup.found) begin
            entry_count <= entry_count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_FINISH: begin
          result_valid <= pend_valid;
          if (pend_valid) begin
            kind             <= pend_kind;
            status           <= nhm_pkg::ST_IGNORED;
            node_address     <= pend_addr;
            sequence_skipped <= pend_skip;
            last_result      <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          result_valid <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/nhm_checker.sv
module nhm_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [1:0] kind,
  input logic [2:0] status,
  input logic       last_result
);

  // An accepted request keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  // A receive status is always the only, hence last, result.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == nhm_pkg::KIND_STATUS |-> last_result)
    else $error("receive status not marked last");

  // Warnings and alerts carry a zero status.
  a_node_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != nhm_pkg::KIND_STATUS |-> status == nhm_pkg::ST_IGNORED)
    else $error("warning or alert with non-zero status");

  // Nothing follows the last result of a request.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid)
    else $error("result after the last result");

endmodule

bind neighbour_heartbeat_monitor nhm_checker u_nhm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .kind         (kind),
  .status       (status),
  .last_result  (last_result)
);
